// ===== hw/rtl/rse_pkg.sv =====
// rse_pkg: shared constants, status codes and the controller/datapath
// command and status structs of the randomized set engine
// no dependencies
package rse_pkg;

	localparam int SET_DEPTH = 64;
	localparam int IDX_W     = $clog2(SET_DEPTH);
	localparam int CNT_W     = $clog2(SET_DEPTH + 1);
	localparam int VAL_W     = 32;
	localparam int MODE_W    = 2;
	localparam int STAT_W    = 3;

	// random source: 16-bit galois lfsr
	localparam int             RND_W    = 16;
	localparam logic [RND_W-1:0] RND_SEED = 16'hACE1;
	localparam logic [RND_W-1:0] RND_TAPS = 16'hB400;

	// modulo unit retires two quotient bits per cycle
	localparam int DIV_STEPS = RND_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam int                MODE_SAMPLE_BIT = 1;

	localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
	localparam logic [STAT_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

	typedef struct packed {
		logic              load;
		logic              match;
		logic              encode;
		logic              div_start;
		logic              rd_rem;
		logic              commit_ins;
		logic              commit_rem;
		logic              finish;
		logic              take_sample;
		logic [STAT_W-1:0] status;
	} rse_cmd_t;

	typedef struct packed {
		logic is_sample;
		logic is_insert;
		logic hit;
		logic full;
		logic empty;
		logic div_done;
	} rse_stat_t;

endpackage

// ===== hw/rtl/randomized_set_engine.sv =====
// randomized_set_engine: set of distinct 32-bit values with insert, remove
// and random sample; top level joining rse_ctrl and rse_dp
// depends on rse_pkg, rse_ctrl, rse_dp (and rse_div below it)
//
//  channel   ports                        transaction completes when
//  -------   --------------------------   ---------------------------
//  command   start, busy, mode, value     start high and busy low
//  result    done, status, sample_value   done high (one cycle, no stall)
//
// insert and remove: after acceptance, capture, match array compare, match
// encode and commit, then the result register
// sample: after acceptance, modulo start, eight modulo
// steps that each retire two bits of the 16-bit lfsr value, the done flag,
// a memory read and the result register
// set empty on sample: decode, then the result register
// a new command may be accepted in the same cycle that done is shown
// reset clears the member count and seeds the lfsr; no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle
module randomized_set_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [rse_pkg::MODE_W-1:0]        mode,
	input  logic signed [rse_pkg::VAL_W-1:0]  value,
	output logic                              done,
	output logic [rse_pkg::STAT_W-1:0]        status,
	output logic signed [rse_pkg::VAL_W-1:0]  sample_value
);
	import rse_pkg::*;

	// command and status between sequencer and datapath
	rse_cmd_t  cmd;
	rse_stat_t stat;

	// sequencer: walks each operation through its steps
	rse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: member storage, count, lfsr, modulo and result registers
	rse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode),
		.value        (value),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.status       (status),
		.sample_value (sample_value)
	);

	// a result is only ever shown once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// an accepted transaction always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not start");

	// status codes stay within the defined set
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_EMPTY))
		else $error("undefined status code");

	// only a completed sample carries a value
	a_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_DONE)) |-> (sample_value == '0))
		else $error("nonzero sample value on failed transaction");

	// results never come back to back: each needs its own transaction
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

endmodule

// ===== hw/rtl/rse_div.sv =====
// rse_div: iterative restoring modulo unit, two bits per cycle
// depends on rse_pkg
module rse_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rse_pkg::RND_W-1:0] dividend,
	input  logic [rse_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [rse_pkg::CNT_W-1:0] remainder
);
	import rse_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RND_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;

	logic [CNT_W:0]   dext;
	logic [CNT_W:0]   a1;
	logic [CNT_W:0]   a2;
	logic [CNT_W-1:0] r1;
	logic [CNT_W-1:0] r2;

	always_comb begin
		dext = {1'b0, div_q};
		a1   = {rem_q, quo_q[RND_W-1]};
		if (a1 >= dext) begin
			a1 = a1 - dext;
		end
		r1 = a1[CNT_W-1:0];
		a2 = {r1, quo_q[RND_W-2]};
		if (a2 >= dext) begin
			a2 = a2 - dext;
		end
		r2 = a2[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[RND_W-3:0], 2'b00};
			rem_q <= r2;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/rse_dp.sv =====
// rse_dp: datapath with match array, indexed member memory, count,
// lfsr, modulo unit and result registers
// depends on rse_pkg and rse_div
module rse_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [rse_pkg::MODE_W-1:0]        mode,
	input  logic signed [rse_pkg::VAL_W-1:0]  value,
	input  rse_pkg::rse_cmd_t                 cmd,
	output rse_pkg::rse_stat_t                stat,
	output logic                              done,
	output logic [rse_pkg::STAT_W-1:0]        status,
	output logic signed [rse_pkg::VAL_W-1:0]  sample_value
);
	import rse_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic [VAL_W-1:0]  value_q;
	logic [RND_W-1:0]  rnd_q;
	logic [RND_W-1:0]  rnd_next;
	logic [CNT_W-1:0]  count_q;

	logic [VAL_W-1:0]     cam_q [SET_DEPTH];
	logic [VAL_W-1:0]     ram_q [SET_DEPTH];
	logic [VAL_W-1:0]     rdata_q;
	logic [SET_DEPTH-1:0] hit_vec;
	logic [SET_DEPTH-1:0] match_q;
	logic [IDX_W-1:0]     pos_c;
	logic [IDX_W-1:0]     pos_q;
	logic                 hit_q;

	logic [CNT_W-1:0] last_cnt;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	logic             div_done;
	logic [CNT_W-1:0] rem;

	logic                 done_q;
	logic [STAT_W-1:0]    status_q;
	logic [VAL_W-1:0]     sample_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			value_q <= value;
		end
	end

	// lfsr steps once for every accepted sample
	always_comb begin
		rnd_next = {1'b0, rnd_q[RND_W-1:1]};
		if (rnd_q[0]) begin
			rnd_next = rnd_next ^ RND_TAPS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q   <= RND_SEED;
			count_q <= '0;
		end else begin
			if (cmd.load && mode[MODE_SAMPLE_BIT]) begin
				rnd_q <= rnd_next;
			end
			if (cmd.commit_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.commit_rem) begin
				count_q <= last_cnt;
			end
		end
	end

	assign last_cnt = count_q - CNT_W'(1);

	// associative match over live entries
	always_comb begin
		for (int i = 0; i < SET_DEPTH; i++) begin
			hit_vec[i] = (CNT_W'(i) < count_q) && (cam_q[i] == value_q);
		end
	end

	// values are distinct, so at most one bit of the match vector is set
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < SET_DEPTH; i++) begin
			pos_c = pos_c | (match_q[i] ? IDX_W'(i) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			match_q <= hit_vec;
		end
		if (cmd.encode) begin
			hit_q <= |match_q;
			pos_q <= pos_c;
		end
	end

	// shared write port for the match array and the member memory
	always_comb begin
		wr_en   = cmd.commit_ins | cmd.commit_rem;
		wr_addr = cmd.commit_ins ? count_q[IDX_W-1:0] : pos_q;
		wr_data = cmd.commit_ins ? value_q : rdata_q;
		rd_en   = cmd.match | cmd.rd_rem;
		rd_addr = cmd.rd_rem ? rem[IDX_W-1:0] : last_cnt[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cam_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= ram_q[rd_addr];
		end
	end

	rse_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (rnd_q),
		.divisor   (count_q),
		.done      (div_done),
		.remainder (rem)
	);

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.status;
			sample_q <= cmd.take_sample ? rdata_q : '0;
		end
	end

	assign stat.is_sample = mode_q[MODE_SAMPLE_BIT];
	assign stat.is_insert = (mode_q == MODE_INSERT);
	assign stat.hit       = hit_q;
	assign stat.full      = (count_q == CNT_W'(SET_DEPTH));
	assign stat.empty     = (count_q == '0);
	assign stat.div_done  = div_done;

	assign done         = done_q;
	assign status       = status_q;
	assign sample_value = sample_q;

endmodule

// ===== hw/rtl/rse_ctrl.sv =====
// rse_ctrl: operation sequencer for the randomized set engine
// depends on rse_pkg
module rse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rse_pkg::rse_stat_t  stat,
	output rse_pkg::rse_cmd_t   cmd,
	output logic                busy
);
	import rse_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_ENCODE = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_READ   = 3'd5;
	localparam logic [2:0] S_SFIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd        = '0;
		cmd.status = ST_DONE;
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_sample) begin
					if (stat.empty) begin
						cmd.finish = 1'b1;
						cmd.status = ST_EMPTY;
						state_d    = S_IDLE;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end else begin
					cmd.match = 1'b1;
					state_d   = S_ENCODE;
				end
			end
			S_ENCODE: begin
				cmd.encode = 1'b1;
				state_d    = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
				if (stat.is_insert) begin
					if (stat.hit) begin
						cmd.status = ST_PRESENT;
					end else if (stat.full) begin
						cmd.status = ST_FULL;
					end else begin
						cmd.commit_ins = 1'b1;
					end
				end else if (stat.hit) begin
					cmd.commit_rem = 1'b1;
				end else begin
					cmd.status = ST_ABSENT;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_rem = 1'b1;
				state_d    = S_SFIN;
			end
			S_SFIN: begin
				cmd.finish      = 1'b1;
				cmd.take_sample = 1'b1;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
